// ===== design/io_resource_free_list_allocator_assert.svh =====
// Assertion macros used by the allocator design file.
`ifndef IO_RESOURCE_FREE_LIST_ALLOCATOR_ASSERT_SVH
`define IO_RESOURCE_FREE_LIST_ALLOCATOR_ASSERT_SVH

// Same-cycle implication, disabled while in reset.
`define IORFL_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("allocator check failed");

// Next-cycle implication, disabled while in reset.
`define IORFL_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("allocator check failed");

`endif

// ===== design/iorfl_pkg.sv =====
package iorfl_pkg;

  localparam int unsigned KINDS = 3;

  typedef enum logic [2:0] {
    OP_ALLOC_DEV  = 3'd0,
    OP_REL_DEV    = 3'd1,
    OP_ALLOC_CTRL = 3'd2,
    OP_REL_CTRL   = 3'd3,
    OP_ALLOC_CHAN = 3'd4,
    OP_REL_CHAN   = 3'd5
  } opcode_t;

  typedef enum logic [1:0] {
    ST_GRANTED      = 2'd0,
    ST_RELEASED     = 2'd1,
    ST_ALLOC_REFUSE = 2'd2,
    ST_REL_REFUSE   = 2'd3
  } status_t;

endpackage

// ===== design/iorfl_ram.sv =====
module iorfl_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [AW-1:0]        waddr,
  input  logic [WIDTH-1:0]     wdata,
  input  logic                 re,
  input  logic [AW-1:0]        raddr,
  output logic [WIDTH-1:0]     rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== design/io_resource_free_list_allocator.sv =====
// Channel  | Direction | Handshake          | Payload
// request  | in        | in_valid/in_stall  | opcode, process_id
// result   | out       | out_valid/out_stall| status, resource_id, process_blocked
//
// A request reads the holding entry and the free-list heads from their RAMs as it
// is accepted (registered reads), then updates and writes back in S_EXEC.
// After reset an init sweep over max(max list size, NUM_PROCESSES) addresses loads
// the free lists with ascending ids and clears the holding RAM; in_stall is high.
// A waiting result sits in the output register; the next request is accepted
// meanwhile and holds in its update cycle until the output register frees up.
module io_resource_free_list_allocator #(
  parameter int unsigned NUM_DEVICES     = 4,
  parameter int unsigned NUM_CONTROLLERS = 4,
  parameter int unsigned NUM_CHANNELS    = 4,
  parameter int unsigned NUM_PROCESSES   = 8
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [2:0] opcode,
  input  logic [2:0] process_id,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [1:0] status,
  output logic [1:0] resource_id,
  output logic       process_blocked
);

  localparam int unsigned KINDS   = iorfl_pkg::KINDS;
  localparam int unsigned MAX_CAP01 =
    (NUM_DEVICES > NUM_CONTROLLERS) ? NUM_DEVICES : NUM_CONTROLLERS;
  localparam int unsigned MAX_CAP = (MAX_CAP01 > NUM_CHANNELS) ? MAX_CAP01 : NUM_CHANNELS;
  localparam int unsigned LIST_AW = (MAX_CAP > 1) ? $clog2(MAX_CAP) : 1;
  localparam int unsigned IDW     = LIST_AW;
  localparam int unsigned CW      = LIST_AW + 1;
  localparam int unsigned PW      = (NUM_PROCESSES > 1) ? $clog2(NUM_PROCESSES) : 1;
  localparam int unsigned HW      = 1 + KINDS + KINDS * IDW;
  localparam int unsigned SWEEP_N = (MAX_CAP > NUM_PROCESSES) ? MAX_CAP : NUM_PROCESSES;
  localparam int unsigned SWW     = $clog2(SWEEP_N + 1);

  localparam logic [CW-1:0] CAP0 = CW'(NUM_DEVICES);
  localparam logic [CW-1:0] CAP1 = CW'(NUM_CONTROLLERS);
  localparam logic [CW-1:0] CAP2 = CW'(NUM_CHANNELS);

  typedef enum logic [1:0] {
    S_INIT,
    S_IDLE,
    S_EXEC
  } state_t;

  state_t              state;
  logic [SWW-1:0]      sweep;
  logic [LIST_AW-1:0]  head [KINDS];
  logic [CW-1:0]       cnt  [KINDS];
  logic [2:0]          op_q;
  logic                pvalid_q;
  logic [PW-1:0]       paddr_q;

  logic                accept;
  logic                go;
  logic                in_pvalid;
  logic [PW-1:0]       in_paddr;

  logic                op_ok;
  logic                is_rel;
  logic [1:0]          kind;
  logic [CW-1:0]       cap_k;
  logic [LIST_AW-1:0]  head_k;
  logic [CW-1:0]       cnt_k;
  logic [CW-1:0]       tail_sum;
  logic [LIST_AW-1:0]  tail;
  logic [LIST_AW-1:0]  head_inc;
  logic                do_alloc;
  logic                do_rel;
  logic                do_push;
  logic                held_v;
  logic [IDW-1:0]      held_id;
  logic                held_blk;
  logic [IDW-1:0]      grant_id;
  logic [1:0]          status_next;
  logic [1:0]          rid_next;
  logic                blk_next;

  logic [HW-1:0]       held_rdata;
  logic [HW-1:0]       held_wdata;
  logic [HW-1:0]       held_upd;
  logic                held_we;
  logic [PW-1:0]       held_waddr;
  logic [IDW-1:0]      fl_rdata [KINDS];
  logic                sweep_fl;
  logic                sweep_held;

  assign in_stall  = (state != S_IDLE);
  assign accept    = in_valid && !in_stall;
  assign go        = (state == S_EXEC) && !(out_valid && out_stall);
  assign in_pvalid = (32'(process_id) < NUM_PROCESSES);
  assign in_paddr  = in_pvalid ? PW'(process_id) : '0;

  assign sweep_fl   = (state == S_INIT) && (sweep < SWW'(MAX_CAP));
  assign sweep_held = (state == S_INIT) && (sweep < SWW'(NUM_PROCESSES));

  // Decode and update of the request in S_EXEC, from the registered RAM reads.
  always_comb begin
    op_ok    = (op_q <= 3'(iorfl_pkg::OP_REL_CHAN));
    is_rel   = op_q[0];
    kind     = op_ok ? op_q[2:1] : 2'd0;
    case (kind)
      2'd0:    cap_k = CAP0;
      2'd1:    cap_k = CAP1;
      default: cap_k = CAP2;
    endcase
    head_k   = head[kind];
    cnt_k    = cnt[kind];
    held_v   = held_rdata[KINDS * IDW + 32'(kind)];
    held_id  = held_rdata[32'(kind) * IDW +: IDW];
    held_blk = held_rdata[HW-1];
    grant_id = fl_rdata[kind];

    tail_sum = CW'(head_k) + cnt_k;
    tail     = (tail_sum >= cap_k) ? LIST_AW'(tail_sum - cap_k) : LIST_AW'(tail_sum);
    head_inc = ((CW'(head_k) + CW'(1)) == cap_k) ? '0 : head_k + LIST_AW'(1);

    do_alloc = op_ok && pvalid_q && !is_rel && (cnt_k != '0) && !held_v;
    do_rel   = op_ok && pvalid_q && is_rel && held_v;
    do_push  = do_rel && (cnt_k < cap_k);

    if (!op_ok) begin
      status_next = iorfl_pkg::ST_REL_REFUSE;
    end else if (is_rel) begin
      status_next = do_rel ? iorfl_pkg::ST_RELEASED : iorfl_pkg::ST_REL_REFUSE;
    end else begin
      status_next = do_alloc ? iorfl_pkg::ST_GRANTED : iorfl_pkg::ST_ALLOC_REFUSE;
    end

    if (do_alloc) begin
      rid_next = 2'(grant_id);
    end else if (do_rel) begin
      rid_next = 2'(held_id);
    end else begin
      rid_next = 2'd0;
    end

    if (!pvalid_q) begin
      blk_next = 1'b0;
    end else if (do_alloc) begin
      blk_next = 1'b1;
    end else if (do_rel) begin
      blk_next = 1'b0;
    end else begin
      blk_next = held_blk;
    end

    held_upd = held_rdata;
    held_upd[HW-1] = blk_next;
    held_upd[KINDS * IDW + 32'(kind)] = do_alloc;
    held_upd[32'(kind) * IDW +: IDW] = do_alloc ? grant_id : '0;
  end

  assign held_we    = sweep_held || (go && (do_alloc || do_rel));
  assign held_waddr = (state == S_INIT) ? sweep[PW-1:0] : paddr_q;
  assign held_wdata = (state == S_INIT) ? '0 : held_upd;

  iorfl_ram #(
    .WIDTH (HW),
    .DEPTH (NUM_PROCESSES)
  ) u_held_ram (
    .clk   (clk),
    .we    (held_we),
    .waddr (held_waddr),
    .wdata (held_wdata),
    .re    (accept),
    .raddr (in_paddr),
    .rdata (held_rdata)
  );

  for (genvar g = 0; g < KINDS; g++) begin : g_list
    logic               fl_we;
    logic [LIST_AW-1:0] fl_waddr;
    logic [IDW-1:0]     fl_wdata;

    // Init loads ascending ids; a release pushes at the tail.
    assign fl_we    = sweep_fl || (go && do_push && (kind == 2'(g)));
    assign fl_waddr = (state == S_INIT) ? sweep[LIST_AW-1:0] : tail;
    assign fl_wdata = (state == S_INIT) ? sweep[IDW-1:0] : held_id;

    iorfl_ram #(
      .WIDTH (IDW),
      .DEPTH (MAX_CAP)
    ) u_list_ram (
      .clk   (clk),
      .we    (fl_we),
      .waddr (fl_waddr),
      .wdata (fl_wdata),
      .re    (accept),
      .raddr (head[g]),
      .rdata (fl_rdata[g])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_INIT;
      sweep     <= '0;
      out_valid <= 1'b0;
      head[0]   <= '0;
      head[1]   <= '0;
      head[2]   <= '0;
      cnt[0]    <= CAP0;
      cnt[1]    <= CAP1;
      cnt[2]    <= CAP2;
    end else begin
      unique case (state)
        S_INIT: begin
          sweep <= sweep + SWW'(1);
          if (sweep == SWW'(SWEEP_N - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            state    <= S_EXEC;
            op_q     <= opcode;
            pvalid_q <= in_pvalid;
            paddr_q  <= in_paddr;
          end
        end
        S_EXEC: begin
          if (go) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_INIT;
      endcase

      if (go) begin
        out_valid       <= 1'b1;
        status          <= status_next;
        resource_id     <= rid_next;
        process_blocked <= blk_next;
        if (do_alloc) begin
          head[kind] <= head_inc;
          cnt[kind]  <= cnt_k - CW'(1);
        end else if (do_push) begin
          cnt[kind]  <= cnt_k + CW'(1);
        end
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

`include "io_resource_free_list_allocator_assert.svh"

  `IORFL_ASSERT_IMP(a_accept_only_idle, accept, state == S_IDLE)
  `IORFL_ASSERT_NEXT(a_exec_after_accept, accept, state == S_EXEC)
  `IORFL_ASSERT_IMP(a_dev_count_bound, state != S_INIT, cnt[0] <= CAP0)
  `IORFL_ASSERT_IMP(a_grant_blocks,
    out_valid && (status == iorfl_pkg::ST_GRANTED), process_blocked)
  `IORFL_ASSERT_IMP(a_release_readies,
    out_valid && (status == iorfl_pkg::ST_RELEASED), !process_blocked)

endmodule
